FILE: hw/rtl/rtbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtbs_pkg
// Shared constants, codes and controller/datapath types of the beam stack.
// ----------------------------------------------------------------------------
package rtbs_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 32;

   localparam int SS_W    = 7;
   localparam int SCORE_W = 32;
   localparam int ID_W    = 16;
   localparam int RANK_W  = 6;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_FLUSH = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_FLUSH = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MATCH,
      ST_ADD_RD,
      ST_ADD_UPD,
      ST_FL_INIT,
      ST_MARK,
      ST_RANK_I,
      ST_RANK_J0,
      ST_RANK_STEP,
      ST_RANK_WR,
      ST_EM_RD,
      ST_EM_OUT,
      ST_CLR
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MATCH,
      OP_ADD_RD,
      OP_ADD_UPD,
      OP_FL_INIT,
      OP_MARK,
      OP_RANK_I,
      OP_RANK_J0,
      OP_RANK_STEP,
      OP_RANK_WR,
      OP_EM_RD,
      OP_EM_OUT,
      OP_CLR
   } op_type;

   typedef struct packed {
      logic out_free;
      logic empty;
      logic j_last;
      logic i_last;
      logic e_last;
   } status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/rtbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtbs_ctrl
// Sequencer: walks add, flush (rank count + emit) and clear through the
// datapath, one datapath operation per cycle, holding while the response register is full.
// ----------------------------------------------------------------------------
module rtbs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_func,
   output logic                     req_ready,
   output rtbs_pkg::op_type         op,
   input  wire rtbs_pkg::status_type status
);

   rtbs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtbs_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  rtbs_pkg::FUNC_ADD:   state_in = rtbs_pkg::ST_MATCH;
                  rtbs_pkg::FUNC_FLUSH: state_in = rtbs_pkg::ST_FL_INIT;
                  rtbs_pkg::FUNC_CLEAR: state_in = rtbs_pkg::ST_CLR;
                  default:              state_in = rtbs_pkg::ST_IDLE;
               endcase
            end
         end
         rtbs_pkg::ST_MATCH:   state_in = rtbs_pkg::ST_ADD_RD;
         rtbs_pkg::ST_ADD_RD:  state_in = rtbs_pkg::ST_ADD_UPD;
         rtbs_pkg::ST_ADD_UPD: begin
            if (status.out_free) state_in = rtbs_pkg::ST_IDLE;
         end
         rtbs_pkg::ST_FL_INIT: begin
            state_in = status.empty ? rtbs_pkg::ST_MARK : rtbs_pkg::ST_RANK_I;
         end
         rtbs_pkg::ST_MARK: begin
            if (status.out_free) state_in = rtbs_pkg::ST_IDLE;
         end
         rtbs_pkg::ST_RANK_I:  state_in = rtbs_pkg::ST_RANK_J0;
         rtbs_pkg::ST_RANK_J0: state_in = rtbs_pkg::ST_RANK_STEP;
         rtbs_pkg::ST_RANK_STEP: begin
            if (status.j_last) state_in = rtbs_pkg::ST_RANK_WR;
         end
         rtbs_pkg::ST_RANK_WR: begin
            state_in = status.i_last ? rtbs_pkg::ST_EM_RD : rtbs_pkg::ST_RANK_I;
         end
         rtbs_pkg::ST_EM_RD: state_in = rtbs_pkg::ST_EM_OUT;
         rtbs_pkg::ST_EM_OUT: begin
            if (status.out_free) begin
               state_in = status.e_last ? rtbs_pkg::ST_IDLE : rtbs_pkg::ST_EM_RD;
            end
         end
         rtbs_pkg::ST_CLR: begin
            if (status.out_free) state_in = rtbs_pkg::ST_IDLE;
         end
         default: state_in = rtbs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      op        = rtbs_pkg::OP_NONE;
      case (state_ff)
         rtbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = rtbs_pkg::OP_LOAD;
         end
         rtbs_pkg::ST_MATCH:  op = rtbs_pkg::OP_MATCH;
         rtbs_pkg::ST_ADD_RD: op = rtbs_pkg::OP_ADD_RD;
         rtbs_pkg::ST_ADD_UPD: begin
            if (status.out_free) op = rtbs_pkg::OP_ADD_UPD;
         end
         rtbs_pkg::ST_FL_INIT: op = rtbs_pkg::OP_FL_INIT;
         rtbs_pkg::ST_MARK: begin
            if (status.out_free) op = rtbs_pkg::OP_MARK;
         end
         rtbs_pkg::ST_RANK_I:    op = rtbs_pkg::OP_RANK_I;
         rtbs_pkg::ST_RANK_J0:   op = rtbs_pkg::OP_RANK_J0;
         rtbs_pkg::ST_RANK_STEP: op = rtbs_pkg::OP_RANK_STEP;
         rtbs_pkg::ST_RANK_WR:   op = rtbs_pkg::OP_RANK_WR;
         rtbs_pkg::ST_EM_RD:     op = rtbs_pkg::OP_EM_RD;
         rtbs_pkg::ST_EM_OUT: begin
            if (status.out_free) op = rtbs_pkg::OP_EM_OUT;
         end
         rtbs_pkg::ST_CLR: begin
            if (status.out_free) op = rtbs_pkg::OP_CLR;
         end
         default: op = rtbs_pkg::OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/rtbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtbs_dp
// Datapath: key registers with parallel match, score/handle memory, sorted
// output memory, rank counters and the response register.
// ----------------------------------------------------------------------------
module rtbs_dp #(
   parameter int CAPACITY = rtbs_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = rtbs_pkg::KEY_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rtbs_pkg::op_type                  op,
   output rtbs_pkg::status_type                   status,
   input  wire logic [31:0]                       req_recomb_key,
   input  wire logic signed [rtbs_pkg::SCORE_W-1:0] req_score,
   input  wire logic [rtbs_pkg::ID_W-1:0]         req_hypo_id,
   input  wire logic                              csr_wr_en,
   input  wire logic [rtbs_pkg::SS_W-1:0]         csr_wr_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_kind,
   output logic                                   rsp_accepted,
   output logic                                   rsp_other_valid,
   output logic [rtbs_pkg::ID_W-1:0]              rsp_item_id,
   output logic signed [rtbs_pkg::SCORE_W-1:0]    rsp_item_score,
   output logic [rtbs_pkg::RANK_W-1:0]            rsp_rank,
   output logic                                   rsp_entry_valid,
   output logic                                   rsp_overflow,
   output logic                                   rsp_last
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CW    = IDX_W + 1;
   localparam int SW    = rtbs_pkg::SCORE_W;
   localparam int IW    = rtbs_pkg::ID_W;
   localparam int LW    = rtbs_pkg::SS_W;

   // request payload
   logic [KEY_BITS-1:0]  key_ff;
   logic signed [SW-1:0] score_ff;
   logic [IW-1:0]        id_ff;

   // table
   logic [KEY_BITS-1:0]  keys_ff [CAPACITY];
   logic [SW-1:0]        score_mem [CAPACITY];
   logic [IW-1:0]        id_mem [CAPACITY];
   logic [SW-1:0]        srt_score_mem [CAPACITY];
   logic [IW-1:0]        srt_id_mem [CAPACITY];
   logic signed [SW-1:0] rd_score_ff;
   logic [IW-1:0]        rd_id_ff;
   logic [SW-1:0]        srt_score_ff;
   logic [IW-1:0]        srt_id_ff;

   logic [CW-1:0]        count_ff;
   logic [LW-1:0]        ss_ff;
   logic [LW-1:0]        lim_ff;
   logic [IDX_W-1:0]     i_ff, jr_ff, cnt_ff, e_ff;
   logic signed [SW-1:0] si_ff;
   logic [IW-1:0]        idi_ff;
   logic                 hit_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 rsp_valid_ff;

   logic                 hit_c;
   logic [IDX_W-1:0]     idx_c;
   logic                 full_c, gt_c, new_c, upd_c, before_c;
   logic                 wr_en_c, rd_en_c, srt_wr_c;
   logic [IDX_W-1:0]     wr_addr_c, rd_addr_c;
   logic [CW-1:0]        count_m1_c;
   logic [LW-1:0]        count_l_c;
   logic                 out_free_c;

   // parallel key match; keys are unique, so the hit index is an OR
   always_comb begin
      hit_c = 1'b0;
      idx_c = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if ((CW'(k) < count_ff) && (keys_ff[k] == key_ff)) begin
            hit_c = 1'b1;
            idx_c = idx_c | IDX_W'(k);
         end
      end
   end

   assign full_c     = (count_ff == CW'(CAPACITY));
   assign gt_c       = (score_ff > rd_score_ff);
   assign new_c      = !hit_ff && !full_c;
   assign upd_c      = hit_ff && gt_c;
   assign wr_en_c    = (op == rtbs_pkg::OP_ADD_UPD) && (new_c || upd_c);
   assign wr_addr_c  = hit_ff ? idx_ff : count_ff[IDX_W-1:0];
   assign count_m1_c = count_ff - CW'(1);
   assign count_l_c  = LW'(count_ff);
   // entry jr ranks ahead of entry i: higher score, or tie inserted earlier
   assign before_c   = (rd_score_ff > si_ff) || ((rd_score_ff == si_ff) && (jr_ff < i_ff));
   assign srt_wr_c   = (op == rtbs_pkg::OP_RANK_WR) && (LW'(cnt_ff) < lim_ff);
   assign out_free_c = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rd_en_c   = 1'b1;
      rd_addr_c = i_ff;
      case (op)
         rtbs_pkg::OP_ADD_RD:    rd_addr_c = idx_ff;
         rtbs_pkg::OP_RANK_I:    rd_addr_c = i_ff;
         rtbs_pkg::OP_RANK_J0:   rd_addr_c = '0;
         rtbs_pkg::OP_RANK_STEP: rd_addr_c = jr_ff + IDX_W'(1);
         default:                rd_en_c   = 1'b0;
      endcase
   end

   assign status.out_free = out_free_c;
   assign status.empty    = (count_ff == '0);
   assign status.j_last   = ({1'b0, jr_ff} == count_m1_c);
   assign status.i_last   = ({1'b0, i_ff} == count_m1_c);
   assign status.e_last   = (LW'(e_ff) + LW'(1) == lim_ff);

   // memories
   always_ff @(posedge clock) begin
      if (wr_en_c) begin
         score_mem[wr_addr_c] <= score_ff;
         id_mem[wr_addr_c]    <= id_ff;
      end
      if (rd_en_c) begin
         rd_score_ff <= score_mem[rd_addr_c];
         rd_id_ff    <= id_mem[rd_addr_c];
      end
      if (srt_wr_c) begin
         srt_score_mem[cnt_ff] <= si_ff;
         srt_id_mem[cnt_ff]    <= idi_ff;
      end
      if (op == rtbs_pkg::OP_EM_RD) begin
         srt_score_ff <= srt_score_mem[e_ff];
         srt_id_ff    <= srt_id_mem[e_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ss_ff        <= '0;
         lim_ff       <= '0;
         i_ff         <= '0;
         jr_ff        <= '0;
         cnt_ff       <= '0;
         e_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) ss_ff <= csr_wr_data;
         case (op)
            rtbs_pkg::OP_ADD_UPD: begin
               if (new_c) count_ff <= count_ff + CW'(1);
            end
            rtbs_pkg::OP_CLR: count_ff <= '0;
            rtbs_pkg::OP_FL_INIT: begin
               i_ff   <= '0;
               e_ff   <= '0;
               lim_ff <= ((ss_ff != '0) && (ss_ff < count_l_c)) ? ss_ff : count_l_c;
            end
            rtbs_pkg::OP_RANK_J0: begin
               jr_ff  <= '0;
               cnt_ff <= '0;
            end
            rtbs_pkg::OP_RANK_STEP: begin
               jr_ff <= jr_ff + IDX_W'(1);
               if (before_c) cnt_ff <= cnt_ff + IDX_W'(1);
            end
            rtbs_pkg::OP_RANK_WR: i_ff <= i_ff + IDX_W'(1);
            rtbs_pkg::OP_EM_OUT:  e_ff <= e_ff + IDX_W'(1);
            default: ;
         endcase
         case (op)
            rtbs_pkg::OP_ADD_UPD, rtbs_pkg::OP_MARK,
            rtbs_pkg::OP_EM_OUT, rtbs_pkg::OP_CLR: rsp_valid_ff <= 1'b1;
            default: begin
               if (rsp_ready) rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (op == rtbs_pkg::OP_ADD_UPD && new_c) keys_ff[count_ff[IDX_W-1:0]] <= key_ff;
      case (op)
         rtbs_pkg::OP_LOAD: begin
            key_ff   <= KEY_BITS'(req_recomb_key);
            score_ff <= req_score;
            id_ff    <= req_hypo_id;
         end
         rtbs_pkg::OP_MATCH: begin
            hit_ff <= hit_c;
            idx_ff <= idx_c;
         end
         rtbs_pkg::OP_RANK_J0: begin
            si_ff  <= rd_score_ff;
            idi_ff <= rd_id_ff;
         end
         rtbs_pkg::OP_ADD_UPD: begin
            rsp_kind        <= rtbs_pkg::KIND_ADD;
            rsp_accepted    <= new_c || upd_c;
            rsp_other_valid <= hit_ff;
            rsp_item_id     <= hit_ff ? rd_id_ff : '0;
            rsp_item_score  <= '0;
            rsp_rank        <= '0;
            rsp_entry_valid <= 1'b0;
            rsp_overflow    <= !hit_ff && full_c;
            rsp_last        <= 1'b1;
         end
         rtbs_pkg::OP_MARK, rtbs_pkg::OP_CLR: begin
            rsp_kind        <= (op == rtbs_pkg::OP_MARK) ? rtbs_pkg::KIND_FLUSH
                                                         : rtbs_pkg::KIND_CLEAR;
            rsp_accepted    <= 1'b0;
            rsp_other_valid <= 1'b0;
            rsp_item_id     <= '0;
            rsp_item_score  <= '0;
            rsp_rank        <= '0;
            rsp_entry_valid <= 1'b0;
            rsp_overflow    <= 1'b0;
            rsp_last        <= 1'b1;
         end
         rtbs_pkg::OP_EM_OUT: begin
            rsp_kind        <= rtbs_pkg::KIND_FLUSH;
            rsp_accepted    <= 1'b0;
            rsp_other_valid <= 1'b0;
            rsp_item_id     <= srt_id_ff;
            rsp_item_score  <= srt_score_ff;
            rsp_rank        <= rtbs_pkg::RANK_W'(e_ff);
            rsp_entry_valid <= 1'b1;
            rsp_overflow    <= 1'b0;
            rsp_last        <= status.e_last;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/recombining_topk_beam_stack_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// recombining_topk_beam_stack_core
// Beam-search stack with key recombination and sorted, pruned flush.
// ----------------------------------------------------------------------------
// One request at a time. An add steps through key match over all key
// registers, memory read of the matching entry, then update and response load.
// A clear resets the entry count and loads its response. A flush of n entries
// ranks each entry by a counting pass over the single-port score memory, then
// reads the sorted memory and emits the m entries kept in rank order (all of
// them when the beam width is zero or not below n). The response register
// lets the next request be taken while a response waits.
module recombining_topk_beam_stack_core #(
   parameter int CAPACITY = rtbs_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = rtbs_pkg::KEY_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_func,
   input  wire logic [31:0]                         req_recomb_key,
   input  wire logic signed [rtbs_pkg::SCORE_W-1:0] req_score,
   input  wire logic [rtbs_pkg::ID_W-1:0]           req_hypo_id,
   input  wire logic                                csr_wr_en,
   input  wire logic [rtbs_pkg::SS_W-1:0]           csr_wr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_kind,
   output logic                                     rsp_accepted,
   output logic                                     rsp_other_valid,
   output logic [rtbs_pkg::ID_W-1:0]                rsp_item_id,
   output logic signed [rtbs_pkg::SCORE_W-1:0]      rsp_item_score,
   output logic [rtbs_pkg::RANK_W-1:0]              rsp_rank,
   output logic                                     rsp_entry_valid,
   output logic                                     rsp_overflow,
   output logic                                     rsp_last
);

   rtbs_pkg::op_type     op;
   rtbs_pkg::status_type status;

   rtbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .op        (op),
      .status    (status)
   );

   rtbs_dp #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .status          (status),
      .req_recomb_key  (req_recomb_key),
      .req_score       (req_score),
      .req_hypo_id     (req_hypo_id),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_accepted    (rsp_accepted),
      .rsp_other_valid (rsp_other_valid),
      .rsp_item_id     (rsp_item_id),
      .rsp_item_score  (rsp_item_score),
      .rsp_rank        (rsp_rank),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_add_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == rtbs_pkg::FUNC_ADD) |=> !req_ready)
      else $error("add request did not occupy the sequencer");

   a_add_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == rtbs_pkg::KIND_ADD) |->
         !(rsp_accepted && rsp_overflow) && !(rsp_other_valid && rsp_overflow))
      else $error("inconsistent add response flags");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == rtbs_pkg::KIND_FLUSH && !rsp_entry_valid) |-> rsp_last)
      else $error("empty flush marker not final");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == rtbs_pkg::KIND_ADD || rsp_kind == rtbs_pkg::KIND_CLEAR))
         |-> rsp_last)
      else $error("single response not final");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Beam stack test: directed and random add/flush/clear requests with random
// handshake gaps, checked against a built-in table model of the stack.
// ----------------------------------------------------------------------------
module tb;

   localparam int CAP = rtbs_pkg::CAPACITY_DEF;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  kind;
      logic        accepted;
      logic        other_valid;
      logic [15:0] item_id;
      logic [31:0] item_score;
      logic [5:0]  rank;
      logic        entry_valid;
      logic        overflow;
      logic        last;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = rtbs_pkg::FUNC_ADD;
   logic [31:0] req_recomb_key = '0;
   logic signed [31:0] req_score = '0;
   logic [15:0] req_hypo_id = '0;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic        rsp_accepted, rsp_other_valid, rsp_entry_valid, rsp_overflow, rsp_last;
   logic [15:0] rsp_item_id;
   logic signed [31:0] rsp_item_score;
   logic [5:0]  rsp_rank;

   recombining_topk_beam_stack_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_recomb_key(req_recomb_key), .req_score(req_score),
      .req_hypo_id(req_hypo_id),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_accepted(rsp_accepted), .rsp_other_valid(rsp_other_valid),
      .rsp_item_id(rsp_item_id), .rsp_item_score(rsp_item_score),
      .rsp_rank(rsp_rank), .rsp_entry_valid(rsp_entry_valid),
      .rsp_overflow(rsp_overflow), .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   // model state
   logic [31:0] tbl_key [CAP];
   logic [31:0] tbl_score [CAP];
   logic [15:0] tbl_id [CAP];
   int          tbl_count;
   logic [6:0]  beam_width;

   rsp_type expected_rsps[$];
   int   errors;
   int   idle_cycles;
   int   rsp_hold_len; // receiver holds off while nonzero

   function automatic rsp_type blank_rsp(logic [1:0] k);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void predict_stack(logic [1:0] f, logic [31:0] key,
                                         logic [31:0] sc, logic [15:0] id);
      rsp_type r;
      int   n, lim, rk;
      rsp_type sorted [CAP];
      if (f == rtbs_pkg::FUNC_ADD) begin
         r = blank_rsp(rtbs_pkg::KIND_ADD);
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == key) begin
               r.other_valid = 1'b1;
               r.item_id = tbl_id[i];
               if ($signed(sc) > $signed(tbl_score[i])) begin
                  r.accepted = 1'b1;
                  tbl_score[i] = sc;
                  tbl_id[i] = id;
               end
               expected_rsps.push_back(r);
               return;
            end
         end
         if (tbl_count >= CAP) begin
            r.overflow = 1'b1;
         end else begin
            tbl_key[tbl_count] = key;
            tbl_score[tbl_count] = sc;
            tbl_id[tbl_count] = id;
            tbl_count++;
            r.accepted = 1'b1;
         end
         expected_rsps.push_back(r);
      end else if (f == rtbs_pkg::FUNC_FLUSH) begin
         n = tbl_count;
         if (n == 0) begin
            expected_rsps.push_back(blank_rsp(rtbs_pkg::KIND_FLUSH));
            return;
         end
         lim = (beam_width != 0 && beam_width < n) ? beam_width : n;
         for (int i = 0; i < n; i++) begin
            rk = 0;
            for (int j = 0; j < n; j++) begin
               if (j != i && ($signed(tbl_score[j]) > $signed(tbl_score[i]) ||
                              (tbl_score[j] == tbl_score[i] && j < i)))
                  rk++;
            end
            r = '0;
            r.kind = rtbs_pkg::KIND_FLUSH;
            r.item_id = tbl_id[i];
            r.item_score = tbl_score[i];
            r.rank = rk[5:0];
            r.entry_valid = 1'b1;
            r.last = (rk + 1 == lim);
            sorted[rk] = r;
         end
         for (int i = 0; i < lim; i++) expected_rsps.push_back(sorted[i]);
      end else if (f == rtbs_pkg::FUNC_CLEAR) begin
         tbl_count = 0;
         expected_rsps.push_back(blank_rsp(rtbs_pkg::KIND_CLEAR));
      end
   endfunction

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_accepted, rsp_other_valid, rsp_item_id,
                rsp_item_score, rsp_rank, rsp_entry_valid, rsp_overflow, rsp_last};
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got != want) begin
               $display("%0t: response mismatch expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   // receiver with random stalls; long hold when requested
   always @(negedge clock) begin
      if (rsp_hold_len > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_len <= rsp_hold_len - 1;
      end else if ($urandom_range(0, 3) == 0)
         rsp_ready <= ($urandom_range(0, 1) == 0) ? 1'b1 : 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 9) != 0);
   end

   function automatic int idle_gap();
      int g;
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) g = 0;
      return g;
   endfunction

   // valid stays high into the next request when there is no gap
   task automatic send_request(logic [1:0] f, logic [31:0] key,
                               logic [31:0] sc, logic [15:0] id);
      int g;
      req_valid <= 1'b1;
      req_func <= f;
      req_recomb_key <= key;
      req_score <= sc;
      req_hypo_id <= id;
      do @(posedge clock); while (!req_ready);
      predict_stack(f, key, sc, id);
      @(negedge clock);
      g = idle_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_beam_width(logic [6:0] w);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      beam_width = w;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_directed();
      send_request(rtbs_pkg::FUNC_FLUSH, '0, '0, '0);          // empty flush marker
      send_request(rtbs_pkg::FUNC_ADD, 32'h0, 32'h8000_0000, 16'h0000);
      send_request(rtbs_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      send_request(rtbs_pkg::FUNC_ADD, 32'h1234, 32'h0001_0000, 16'h0011);
      send_request(rtbs_pkg::FUNC_ADD, 32'h1234, 32'h0001_0000, 16'h0022); // equal: rejected
      send_request(rtbs_pkg::FUNC_ADD, 32'h1234, 32'h0000_0000, 16'h0033); // lower: rejected
      send_request(rtbs_pkg::FUNC_ADD, 32'h1234, 32'h0002_0000, 16'h0044); // higher: replaces
      send_request(rtbs_pkg::FUNC_ADD, 32'h5555, 32'h0002_0000, 16'h0055); // tie with earlier
      send_request(rtbs_pkg::FUNC_ADD, 32'hAAAA_AAAA, 32'hFFFF_0000, 16'hAAAA);
      send_request(rtbs_pkg::FUNC_FLUSH, '0, '0, '0);
      send_request(2'd3, 32'h1234, 32'h7FFF_FFFF, 16'h9999); // ignored
      send_request(rtbs_pkg::FUNC_FLUSH, '0, '0, '0);
      set_beam_width(7'd1);
      send_request(rtbs_pkg::FUNC_FLUSH, '0, '0, '0);
      set_beam_width(7'd3);
      send_request(rtbs_pkg::FUNC_FLUSH, '0, '0, '0);
      send_request(rtbs_pkg::FUNC_CLEAR, '0, '0, '0);
      send_request(rtbs_pkg::FUNC_FLUSH, '0, '0, '0);
   endtask

   // fill past capacity to hit overflow, then flush the full table
   task automatic test_overflow();
      set_beam_width(7'd64);
      for (int i = 0; i < CAP + 3; i++)
         send_request(rtbs_pkg::FUNC_ADD, 32'h100 + 32'(i), $urandom_range(0, 7),
                      16'($urandom));
      send_request(rtbs_pkg::FUNC_ADD, 32'h105, 32'h7FFF_FFFF, 16'h1234);
      send_request(rtbs_pkg::FUNC_FLUSH, '0, '0, '0);
      send_request(rtbs_pkg::FUNC_CLEAR, '0, '0, '0);
   endtask

   // receiver holds off while the sender keeps offering adds
   task automatic test_backpressure();
      drain();
      rsp_hold_len = 300;
      for (int i = 0; i < 8; i++)
         send_request(rtbs_pkg::FUNC_ADD, $urandom_range(0, 3), $urandom, 16'($urandom));
      drain();
   endtask

   task automatic test_random();
      logic [1:0]  f;
      logic [31:0] key, sc;
      int          r;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_beam_width(7'd0);
            1: set_beam_width(7'd2);
            2: set_beam_width(7'($urandom_range(1, 10)));
            default: set_beam_width(7'd127);
         endcase
         for (int i = 0; i < 43; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80) f = rtbs_pkg::FUNC_ADD;
            else if (r < 90) f = rtbs_pkg::FUNC_FLUSH;
            else if (r < 97) f = rtbs_pkg::FUNC_CLEAR;
            else f = 2'd3;
            key = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
            sc = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 3) - 2;
            send_request(f, key, sc, 16'($urandom));
         end
         send_request(rtbs_pkg::FUNC_FLUSH, '0, '0, '0);
      end
   endtask

   initial begin
      errors = 0;
      idle_cycles = 0;
      rsp_hold_len = 0;
      tbl_count = 0;
      beam_width = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_overflow();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0 && expected_rsps.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
